/* design/rart_pkg.sv */
`default_nettype none

package rart_pkg;

    // Request kinds carried in the action field.
    localparam logic ACT_ASSIGN = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    // Pending-assign codes held for each inner node.
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ZERO = 2'd1;
    localparam logic [1:0] PEND_ONE  = 2'd2;

    // Reset value of the element count register.
    localparam logic [10:0] ELEMENTS_RESET = 11'd1024;

endpackage

`default_nettype wire

/* design/range_assign_range_and_tree.sv */
// Range-assign / range-AND tree over LEAVES one-bit flags (LEAVES = 2**LEVELS).
// Input channel: i_in_valid / o_in_stall carry one request word: i_action
// (assign or query), the half-open range [i_first_index, i_end_index) and
// i_value for an assign. Output channel: o_out_valid / i_out_stall carry one
// result word per request: o_and_result (AND over the range, 1 for an empty
// range, an assign or a rejected request) and o_range_error.
// Configuration: i_cfg_valid / o_cfg_ready write the element count, which is
// always ready; write it only while the block is idle.
// The tree lives in two synchronous RAMs (node AND values and pending
// assigns), each with one write port, walked by a read-modify-write sequencer.
// A request is accepted from idle, then walks the 2*LEVELS push-down steps,
// the range walk (up to LEVELS + 1 levels and a final check), for an assign
// the 2*LEVELS pull-up steps, and the finishing state; the push-down steps
// are drawn out mostly by the single write port of the pending RAM. Invalid
// and empty ranges go from idle straight to the finishing state.
// Requests are handled one at a time; a finished result waits in an output
// register so the next request may be accepted while the receiver stalls.
// After reset a clearing pass over every node address initialises the RAMs,
// and the input is stalled until it ends.
`default_nettype none

module range_assign_range_and_tree #(
    parameter int LEAVES = 1024,
    parameter int LEVELS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_action,
    input  wire logic [10:0] i_first_index,
    input  wire logic [10:0] i_end_index,
    input  wire logic        i_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_and_result,
    output logic             o_range_error,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [10:0] i_cfg_data
);

    localparam int W  = LEVELS + 2;
    localparam int NW = LEVELS + 1;
    localparam int LW = $clog2(LEVELS + 1);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_PUSH_A = 4'd2;
    localparam logic [3:0] S_PUSH_B = 4'd3;
    localparam logic [3:0] S_PUSH_C = 4'd4;
    localparam logic [3:0] S_PUSH_D = 4'd5;
    localparam logic [3:0] S_LO     = 4'd6;
    localparam logic [3:0] S_HI     = 4'd7;
    localparam logic [3:0] S_SH     = 4'd8;
    localparam logic [3:0] S_PULL_A = 4'd9;
    localparam logic [3:0] S_PULL_B = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    // Memories.
    logic        r_node_mem [2*LEAVES];
    logic [1:0]  r_pend_mem [LEAVES];
    logic        r_node_q0, r_node_q1;
    logic [1:0]  r_pend_q;

    logic          node_we, node_wdata;
    logic [NW-1:0] node_waddr, node_ra0, node_ra1;
    logic          pend_we;
    logic [1:0]    pend_wdata;
    logic [LEVELS-1:0] pend_waddr, pend_ra;

    // Control registers.
    logic [3:0]        r_state, n_state;
    logic [NW-1:0]     r_clr, n_clr;
    logic [10:0]       r_elems;
    logic              r_act, n_act;
    logic              r_val, n_val;
    logic [W-1:0]      r_l, n_l, r_r, n_r, r_lo, n_lo, r_hi, n_hi;
    logic [LW-1:0]     r_lv, n_lv;
    logic              r_side, n_side;
    logic [LEVELS-1:0] r_k, n_k;
    logic              r_acc, n_acc;
    logic              r_rdq, n_rdq;
    logic              r_err, n_err;
    logic              r_out_valid, n_out_valid;
    logic              r_out_and, n_out_and;
    logic              r_out_err, n_out_err;

    // Request check and leaf positions.
    logic          accept, req_err, req_empty;
    logic [31:0]   l_full, r_full;
    logic [W-1:0]  side_x, side_base, lv_mask, k_full, hi_dec, lo_inc;
    logic          step_cond, push_last, pull_last;
    logic [NW-1:0] child0, child1;
    logic [1:0]    lo_code;

    assign accept   = i_in_valid && !o_in_stall;
    assign req_err  = (i_first_index > i_end_index) || (i_end_index > r_elems)
                   || (32'(i_end_index) > 32'(LEAVES));
    assign req_empty = (i_first_index == i_end_index);
    assign l_full   = 32'(i_first_index) + 32'(LEAVES);
    assign r_full   = 32'(i_end_index) + 32'(LEAVES);

    // Node on the current level above the left or right boundary.
    assign side_base = r_side ? r_r : r_l;
    assign side_x    = r_side ? (r_r - W'(1)) : r_l;
    assign lv_mask   = (W'(1) << r_lv) - W'(1);
    assign k_full    = side_x >> r_lv;
    assign step_cond = (side_base & lv_mask) != '0;
    assign push_last = (r_lv == LW'(1)) && r_side;
    assign pull_last = (r_lv == LW'(LEVELS)) && r_side;
    assign child0    = {r_k, 1'b0};
    assign child1    = {r_k, 1'b1};
    assign hi_dec    = r_hi - W'(1);
    assign lo_inc    = r_lo + W'(1);
    assign lo_code   = {r_val, ~r_val};

    // Sequencer.
    always_comb begin
        n_state = r_state; n_clr = r_clr; n_act = r_act; n_val = r_val;
        n_l = r_l; n_r = r_r; n_lo = r_lo; n_hi = r_hi; n_lv = r_lv;
        n_side = r_side; n_k = r_k; n_rdq = 1'b0; n_err = r_err;
        n_acc = r_rdq ? (r_acc & r_node_q0) : r_acc;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_and = r_out_and; n_out_err = r_out_err;
        node_we = 1'b0; node_wdata = 1'b0; node_waddr = '0;
        node_ra0 = '0; node_ra1 = '0;
        pend_we = 1'b0; pend_wdata = rart_pkg::PEND_NONE; pend_waddr = '0;
        pend_ra = k_full[LEVELS-1:0];
        case (r_state)
            S_CLEAR: begin
                node_we = 1'b1; node_wdata = 1'b1; node_waddr = r_clr;
                pend_we = !r_clr[LEVELS]; pend_waddr = r_clr[LEVELS-1:0];
                n_clr = r_clr + NW'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_act = i_action; n_val = i_value; n_err = req_err;
                    n_acc = 1'b1;
                    n_l = l_full[W-1:0]; n_r = r_full[W-1:0];
                    n_lv = LW'(LEVELS); n_side = 1'b0;
                    n_state = (req_err || req_empty) ? S_DONE : S_PUSH_A;
                end
            end
            S_PUSH_A: begin
                n_k = k_full[LEVELS-1:0];
                if (step_cond) begin
                    n_state = S_PUSH_B;
                end else if (push_last) begin
                    n_lo = r_l; n_hi = r_r; n_state = S_LO;
                end else begin
                    n_side = !r_side;
                    if (r_side) n_lv = r_lv - LW'(1);
                end
            end
            S_PUSH_B: begin
                if (r_pend_q != rart_pkg::PEND_NONE) begin
                    node_we = 1'b1; node_waddr = child0; node_wdata = r_pend_q[1];
                    pend_we = !child0[LEVELS]; pend_waddr = child0[LEVELS-1:0];
                    pend_wdata = r_pend_q;
                    n_state = S_PUSH_C;
                end else if (push_last) begin
                    n_lo = r_l; n_hi = r_r; n_state = S_LO;
                end else begin
                    n_side = !r_side; n_state = S_PUSH_A;
                    if (r_side) n_lv = r_lv - LW'(1);
                end
            end
            S_PUSH_C: begin
                node_we = 1'b1; node_waddr = child1; node_wdata = r_pend_q[1];
                pend_we = !child1[LEVELS]; pend_waddr = child1[LEVELS-1:0];
                pend_wdata = r_pend_q;
                pend_ra = r_k;
                n_state = S_PUSH_D;
            end
            S_PUSH_D: begin
                pend_we = 1'b1; pend_waddr = r_k; pend_wdata = rart_pkg::PEND_NONE;
                if (push_last) begin
                    n_lo = r_l; n_hi = r_r; n_state = S_LO;
                end else begin
                    n_side = !r_side; n_state = S_PUSH_A;
                    if (r_side) n_lv = r_lv - LW'(1);
                end
            end
            S_LO: begin
                if (r_lo < r_hi) begin
                    if (r_lo[0]) begin
                        if (r_act == rart_pkg::ACT_ASSIGN) begin
                            node_we = 1'b1; node_waddr = r_lo[NW-1:0]; node_wdata = r_val;
                            pend_we = !r_lo[LEVELS]; pend_waddr = r_lo[LEVELS-1:0];
                            pend_wdata = lo_code;
                        end else begin
                            node_ra0 = r_lo[NW-1:0]; n_rdq = 1'b1;
                        end
                        n_lo = lo_inc;
                    end
                    n_state = S_HI;
                end else if (r_act == rart_pkg::ACT_ASSIGN) begin
                    n_lv = LW'(1); n_side = 1'b0; n_state = S_PULL_A;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_HI: begin
                if (r_hi[0]) begin
                    if (r_act == rart_pkg::ACT_ASSIGN) begin
                        node_we = 1'b1; node_waddr = hi_dec[NW-1:0]; node_wdata = r_val;
                        pend_we = !hi_dec[LEVELS]; pend_waddr = hi_dec[LEVELS-1:0];
                        pend_wdata = lo_code;
                    end else begin
                        node_ra0 = hi_dec[NW-1:0]; n_rdq = 1'b1;
                    end
                    n_hi = hi_dec;
                end
                n_state = S_SH;
            end
            S_SH: begin
                n_lo = r_lo >> 1; n_hi = r_hi >> 1; n_state = S_LO;
            end
            S_PULL_A: begin
                n_k = k_full[LEVELS-1:0];
                node_ra0 = {k_full[LEVELS-1:0], 1'b0};
                node_ra1 = {k_full[LEVELS-1:0], 1'b1};
                if (step_cond) begin
                    n_state = S_PULL_B;
                end else if (pull_last) begin
                    n_state = S_DONE;
                end else begin
                    n_side = !r_side;
                    if (r_side) n_lv = r_lv + LW'(1);
                end
            end
            S_PULL_B: begin
                node_we = 1'b1; node_waddr = NW'(r_k); node_wdata = r_node_q0 & r_node_q1;
                if (pull_last) begin
                    n_state = S_DONE;
                end else begin
                    n_side = !r_side; n_state = S_PULL_A;
                    if (r_side) n_lv = r_lv + LW'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_err = r_err;
                    n_out_and = r_err || (r_act == rart_pkg::ACT_ASSIGN) || n_acc;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_elems <= rart_pkg::ELEMENTS_RESET;
            r_rdq <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_rdq <= n_rdq;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_elems <= i_cfg_data;
            end
        end
        r_act <= n_act; r_val <= n_val; r_l <= n_l; r_r <= n_r;
        r_lo <= n_lo; r_hi <= n_hi; r_lv <= n_lv; r_side <= n_side;
        r_k <= n_k; r_acc <= n_acc; r_err <= n_err;
        r_out_and <= n_out_and; r_out_err <= n_out_err;
    end

    // Node RAM: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            r_node_mem[node_waddr] <= node_wdata;
        end
        r_node_q0 <= r_node_mem[node_ra0];
        r_node_q1 <= r_node_mem[node_ra1];
    end

    // Pending-assign RAM: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (pend_we) begin
            r_pend_mem[pend_waddr] <= pend_wdata;
        end
        r_pend_q <= r_pend_mem[pend_ra];
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_and_result  = r_out_and;
    assign o_range_error = r_out_err;
    assign o_cfg_ready   = 1'b1;

`ifndef SYNTHESIS
    // An accepted request always leaves the idle state.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // Node reads for the AND only happen on query requests.
    a_read_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rdq |-> (r_act == rart_pkg::ACT_QUERY))
        else $error("node read captured during an assign");

    // A new result word only appears after the finishing state.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result word raised outside the finishing state");

    // A rejected request never touches the RAMs.
    a_err_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err && r_state != S_CLEAR && r_state != S_IDLE) |-> (!node_we && !pend_we))
        else $error("rejected request wrote the tree");
`endif

endmodule

`default_nettype wire

/* tb/sv/range_assign_range_and_tree_tb.sv */
`timescale 1ns / 1ps

module range_assign_range_and_tree_tb;

    localparam int FLAGS = 1024;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_action = rart_pkg::ACT_ASSIGN;
    logic [10:0] i_first_index = '0;
    logic [10:0] i_end_index = '0;
    logic        i_value = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_and_result;
    logic        o_range_error;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data = '0;

    range_assign_range_and_tree dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_action(i_action), .i_first_index(i_first_index),
        .i_end_index(i_end_index), .i_value(i_value),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_and_result(o_and_result), .o_range_error(o_range_error),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    typedef struct packed {
        logic and_result;
        logic range_error;
    } t_tree_answer;

    // Flat copy of the flag array and the element count register.
    logic         flag_mirror [FLAGS];
    logic [10:0]  element_count;
    t_tree_answer pending_answers [$];
    int           error_count = 0;
    int           requests_sent = 0;
    int           answers_seen = 0;
    bit           quiet = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("TIMEOUT at %0t", $time);
        $display("range_assign_range_and_tree_tb: errors");
        $finish;
    end

    // Works out the answer to one request and applies it to the flag mirror.
    function automatic t_tree_answer apply_request(logic act, logic [10:0] lo,
                                                   logic [10:0] hi, logic val);
        t_tree_answer a;
        int limit;
        limit = (element_count < FLAGS) ? element_count : FLAGS;
        a.and_result = 1'b1;
        a.range_error = 1'b0;
        if (lo > hi || hi > limit) begin
            a.range_error = 1'b1;
            return a;
        end
        for (int k = lo; k < hi; k++) begin
            if (act == rart_pkg::ACT_ASSIGN) flag_mirror[k] = val;
            else a.and_result &= flag_mirror[k];
        end
        return a;
    endfunction

    // Sends one request word, with an occasional idle burst before it.
    task automatic send_request(logic act, logic [10:0] lo, logic [10:0] hi, logic val);
        t_tree_answer expected;
        if (!quiet && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        i_in_valid = 1'b1;
        i_action = act;
        i_first_index = lo;
        i_end_index = hi;
        i_value = val;
        do @(posedge i_clk); while (o_in_stall);
        expected = apply_request(act, lo, hi, val);
        pending_answers = {pending_answers, expected};
        requests_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Waits for the block to drain, then writes the element count.
    task automatic write_element_count(logic [10:0] count);
        wait (pending_answers.size() == 0);
        repeat (150) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = count;
        do @(posedge i_clk); while (!o_cfg_ready);
        element_count = count;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // The receiver stalls in random bursts unless the run is in its quiet part.
    initial begin
        forever begin
            repeat ($urandom_range(1, 12)) begin
                @(negedge i_clk);
                i_out_stall = 1'b0;
            end
            if (!quiet) begin
                repeat ($urandom_range(1, 12)) begin
                    @(negedge i_clk);
                    i_out_stall = !quiet;
                end
            end
        end
    end

    // Compares each result word with the oldest expected answer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            answers_seen++;
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result and=%b err=%b", $time,
                         o_and_result, o_range_error);
                error_count++;
            end else begin
                t_tree_answer want;
                want = pending_answers.pop_front();
                if (want.and_result !== o_and_result) begin
                    $display("%0t: and_result expected %b actual %b", $time,
                             want.and_result, o_and_result);
                    error_count++;
                end
                if (want.range_error !== o_range_error) begin
                    $display("%0t: range_error expected %b actual %b", $time,
                             want.range_error, o_range_error);
                    error_count++;
                end
            end
        end
    end

    // Extremes, empty and invalid ranges, point set and get, whole array.
    task automatic test_directed();
        send_request(rart_pkg::ACT_QUERY, 11'd0, 11'd1024, 1'b0);
        send_request(rart_pkg::ACT_QUERY, 11'd5, 11'd5, 1'b0);
        send_request(rart_pkg::ACT_ASSIGN, 11'd0, 11'd1024, 1'b0);
        send_request(rart_pkg::ACT_QUERY, 11'd0, 11'd1024, 1'b1);
        send_request(rart_pkg::ACT_ASSIGN, 11'd1, 11'd1023, 1'b1);
        send_request(rart_pkg::ACT_QUERY, 11'd1, 11'd1023, 1'b0);
        send_request(rart_pkg::ACT_QUERY, 11'd0, 11'd2, 1'b0);
        send_request(rart_pkg::ACT_ASSIGN, 11'd0, 11'd1, 1'b1);
        send_request(rart_pkg::ACT_QUERY, 11'd0, 11'd1, 1'b0);
        send_request(rart_pkg::ACT_ASSIGN, 11'd1023, 11'd1024, 1'b1);
        send_request(rart_pkg::ACT_QUERY, 11'd0, 11'd1024, 1'b0);
        send_request(rart_pkg::ACT_ASSIGN, 11'd512, 11'd513, 1'b0);
        send_request(rart_pkg::ACT_QUERY, 11'd512, 11'd513, 1'b0);
        send_request(rart_pkg::ACT_QUERY, 11'd511, 11'd512, 1'b0);
        send_request(rart_pkg::ACT_QUERY, 11'd10, 11'd9, 1'b0);
        send_request(rart_pkg::ACT_ASSIGN, 11'd0, 11'd1025, 1'b1);
        send_request(rart_pkg::ACT_ASSIGN, 11'd2047, 11'd2047, 1'b1);
        send_request(rart_pkg::ACT_QUERY, 11'd1024, 11'd1024, 1'b1);
        send_request(rart_pkg::ACT_ASSIGN, 11'd3, 11'd2, 1'b1);
        send_request(rart_pkg::ACT_QUERY, 11'd0, 11'd1024, 1'b1);
    endtask

    // Random requests, mostly valid and short, some long and some out of range.
    task automatic test_random(int count);
        logic [10:0] lo, hi;
        int limit;
        for (int n = 0; n < count; n++) begin
            limit = (element_count < FLAGS) ? element_count : FLAGS;
            case ($urandom_range(0, 9))
                0: begin
                    lo = 11'($urandom_range(0, 2047));
                    hi = 11'($urandom_range(0, 2047));
                end
                1: begin
                    lo = 11'($urandom_range(0, limit));
                    hi = 11'($urandom_range(lo, limit));
                end
                default: begin
                    lo = 11'($urandom_range(0, limit));
                    hi = lo + 11'($urandom_range(0, 16));
                    if (hi > limit) hi = 11'(limit);
                end
            endcase
            send_request(logic'($urandom_range(0, 1)), lo, hi, logic'($urandom_range(0, 1)));
        end
    endtask

    // Changes the element count and probes the new limit and beyond it.
    task automatic test_element_count(logic [10:0] count, int count_random);
        write_element_count(count);
        send_request(rart_pkg::ACT_QUERY, 11'd0, count, 1'b0);
        send_request(rart_pkg::ACT_ASSIGN, 11'd0, count + 11'd1, 1'b1);
        test_random(count_random);
    endtask

    initial begin
        for (int k = 0; k < FLAGS; k++) flag_mirror[k] = 1'b1;
        element_count = rart_pkg::ELEMENTS_RESET;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(200);
        test_element_count(11'd1, 60);
        test_element_count(11'd0, 40);
        test_element_count(11'd2047, 150);
        test_element_count(11'd37, 120);
        test_element_count(11'd700, 150);
        test_element_count(11'd1024, 20);
        quiet = 1'b1;
        test_random(150);

        wait (pending_answers.size() == 0);
        repeat (200) @(negedge i_clk);
        $display("Sent %0d requests and checked %0d results over seven element counts,",
                 requests_sent, answers_seen);
        $display("with empty, out-of-range and whole-array ranges and random stalls.");
        if (error_count == 0 && pending_answers.size() == 0) begin
            $display("range_assign_range_and_tree_tb: clean");
        end else begin
            $display("range_assign_range_and_tree_tb: errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/rart_pkg.sv
design/range_assign_range_and_tree.sv
tb/sv/range_assign_range_and_tree_tb.sv
